// File: hw/rtl/srt_pkg.sv
// shared constants, codes and cell control type for the sorted range table
package srt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ADDR_BITS_DEF   = 48;
  localparam int ID_BITS_DEF     = 16;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COVERED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LEFT  = 2'd2,
    OP_FROM_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/srt_cell.sv
// one table cell: holds a range entry, shifts with its neighbors, compares against the key
module srt_cell #(
  parameter int ADDR_BITS = srt_pkg::ADDR_BITS_DEF,
  parameter int ID_BITS   = srt_pkg::ID_BITS_DEF
) (
  input  logic                 clk,
  input  srt_pkg::cell_ctrl_t  ctrl,
  input  logic [ADDR_BITS-1:0] key,
  input  logic [ADDR_BITS-1:0] new_base,
  input  logic [ADDR_BITS-1:0] new_length,
  input  logic [ID_BITS-1:0]   new_owner,
  input  logic [ADDR_BITS-1:0] left_base,
  input  logic [ADDR_BITS-1:0] left_length,
  input  logic [ID_BITS-1:0]   left_owner,
  input  logic [ADDR_BITS-1:0] right_base,
  input  logic [ADDR_BITS-1:0] right_length,
  input  logic [ID_BITS-1:0]   right_owner,
  output logic [ADDR_BITS-1:0] base,
  output logic [ADDR_BITS-1:0] length,
  output logic [ID_BITS-1:0]   owner,
  output logic                 below,
  output logic                 holds
);
  import srt_pkg::*;

  logic [ADDR_BITS-1:0] offset;

  // offset only matters when key >= base, so it never wraps where used
  assign offset = key - base;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        base   <= new_base;
        length <= new_length;
        owner  <= new_owner;
      end
      OP_FROM_LEFT: begin
        base   <= left_base;
        length <= left_length;
        owner  <= left_owner;
      end
      OP_FROM_RIGHT: begin
        base   <= right_base;
        length <= right_length;
        owner  <= right_owner;
      end
      default: begin
        base   <= base;
        length <= length;
        owner  <= owner;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      below <= key < base;
      holds <= (key >= base) && (offset < length);
    end
  end

endmodule

// File: hw/rtl/sorted_range_table_top.sv
// steps: accept, one registered compare in all cells at once, a binary search over the
// stored entries, then apply; a hit ends the search at the matching probe, a miss when the window is empty
// throughput is set by the binary search; apply stalls while the previous result is not taken, and
// the next beat is taken in idle while a result waits
// table updates (shift up or down one cell) happen in the apply cycle in the cells from the search slot up at once
// reset clears the entry count and handshake state; cell contents are not cleared
module sorted_range_table_top #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_BITS   = srt_pkg::ADDR_BITS_DEF,
  parameter int ID_BITS     = srt_pkg::ID_BITS_DEF,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srt_pkg::REQ_W-1:0]    req_type,
  input  logic [ADDR_BITS-1:0]         addr,
  input  logic [ADDR_BITS-1:0]         length,
  input  logic [ID_BITS-1:0]           owner_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [ID_BITS-1:0]           found_id,
  output logic [CNT_W-1:0]             slot,
  output logic [srt_pkg::STATUS_W-1:0] status
);
  import srt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_SRCH  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t               state;
  logic [REQ_W-1:0]     req_q;
  logic [ADDR_BITS-1:0] key;
  logic [ADDR_BITS-1:0] len_q;
  logic [ID_BITS-1:0]   id_q;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi;
  logic                 hit_q;
  logic [CNT_W-1:0]     count;

  logic [CNT_W-1:0]     mid;
  logic                 adv;
  logic                 finish;
  logic                 do_ins;
  logic                 do_rem;
  logic [ID_BITS-1:0]   sel_owner;
  logic [STATUS_W-1:0]  status_c;

  logic [ADDR_BITS-1:0] cell_base   [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] cell_length [TABLE_DEPTH];
  logic [ID_BITS-1:0]   cell_owner  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_below;
  logic [TABLE_DEPTH-1:0] cell_holds;
  cell_ctrl_t           cell_ctrl   [TABLE_DEPTH];

  assign in_ready = (state == S_IDLE);
  assign mid      = lo + ((hi - lo) >> 1);
  assign adv      = !out_valid || out_ready;
  assign finish   = (state == S_APPLY) && adv;

  // owner of the entry where the search stopped
  always_comb begin
    sel_owner = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (lo == CNT_W'(i)) sel_owner = cell_owner[i];
    end
  end

  assign do_ins = finish && (req_q == REQ_INSERT) && !hit_q &&
                  (count < CNT_W'(TABLE_DEPTH));
  assign do_rem = finish && (req_q == REQ_REMOVE) && hit_q && (sel_owner == id_q);

  always_comb begin
    status_c = ST_DONE;
    if (req_q == REQ_INSERT) begin
      if (hit_q) status_c = ST_COVERED;
      else if (count >= CNT_W'(TABLE_DEPTH)) status_c = ST_FULL;
    end else if (req_q == REQ_REMOVE) begin
      if (!(hit_q && (sel_owner == id_q))) status_c = ST_NO_MATCH;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [ADDR_BITS-1:0] l_base;
    logic [ADDR_BITS-1:0] l_length;
    logic [ID_BITS-1:0]   l_owner;
    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_length;
    logic [ID_BITS-1:0]   r_owner;

    // ends of the row see the new entry on the left and themselves on the right
    if (g == 0) begin : g_first
      assign l_base   = key;
      assign l_length = len_q;
      assign l_owner  = id_q;
    end else begin : g_inner_l
      assign l_base   = cell_base[g-1];
      assign l_length = cell_length[g-1];
      assign l_owner  = cell_owner[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign r_base   = cell_base[g];
      assign r_length = cell_length[g];
      assign r_owner  = cell_owner[g];
    end else begin : g_inner_r
      assign r_base   = cell_base[g+1];
      assign r_length = cell_length[g+1];
      assign r_owner  = cell_owner[g+1];
    end

    always_comb begin
      cell_ctrl[g].cmp_en = (state == S_CMP);
      cell_ctrl[g].op     = OP_HOLD;
      if (do_ins) begin
        if (CNT_W'(g) == lo) cell_ctrl[g].op = OP_LOAD;
        else if (CNT_W'(g) > lo) cell_ctrl[g].op = OP_FROM_LEFT;
      end else if (do_rem) begin
        if ((CNT_W'(g) >= lo) && (g < TABLE_DEPTH - 1)) cell_ctrl[g].op = OP_FROM_RIGHT;
      end
    end

    srt_cell #(
      .ADDR_BITS (ADDR_BITS),
      .ID_BITS   (ID_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (cell_ctrl[g]),
      .key          (key),
      .new_base     (key),
      .new_length   (len_q),
      .new_owner    (id_q),
      .left_base    (l_base),
      .left_length  (l_length),
      .left_owner   (l_owner),
      .right_base   (r_base),
      .right_length (r_length),
      .right_owner  (r_owner),
      .base         (cell_base[g]),
      .length       (cell_length[g]),
      .owner        (cell_owner[g]),
      .below        (cell_below[g]),
      .holds        (cell_holds[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      lo        <= '0;
      hi        <= '0;
      hit_q     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            lo    <= '0;
            hi    <= count;
            hit_q <= 1'b0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) begin
            if (cell_below[mid[IDX_W-1:0]]) begin
              hi <= mid;
            end else if (!cell_holds[mid[IDX_W-1:0]]) begin
              lo <= mid + CNT_W'(1);
            end else begin
              lo    <= mid;
              hit_q <= 1'b1;
              state <= S_APPLY;
            end
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (adv) begin
            if (do_ins) count <= count + CNT_W'(1);
            else if (do_rem) count <= count - CNT_W'(1);
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q <= req_type;
      key   <= addr;
      len_q <= length;
      id_q  <= owner_id;
    end
    if (finish) begin
      hit      <= hit_q;
      found_id <= hit_q ? sel_owner : '0;
      slot     <= lo;
      status   <= status_c;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (lo <= hi) && (hi <= count))
    else $error("search window outside stored entries");

  a_count_only_on_apply: assert property (@(posedge clk) disable iff (rst)
    !finish |=> $stable(count))
    else $error("entry count changed outside apply");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_APPLY))
    else $error("result raised without an apply cycle");

endmodule
